/* rtl/chh_pkg.sv */
package chh_pkg;

  // Field widths
  localparam int XY_W = 16;
  localparam int KIND_W = 3;

  // CORDIC angle format: degrees scaled by 2^ANGLE_FRAC
  localparam int ANGLE_FRAC = 23;
  localparam int ANGLE_W = 34;
  localparam int ATAN_W = 29;
  localparam int PRESCALE_SHIFT = 14;
  localparam int ATAN_DEPTH = 24;

  // Defaults for the top level parameters
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int HEADING_FRAC_DEF = 7;

  // Offsets are accepted only strictly inside this bound
  localparam logic signed [XY_W-1:0] LOAD_LIMIT = 16'sd30000;

  // Calibration window reset values
  localparam logic signed [XY_W-1:0] WIN_MAX_RST = 16'sh8000;
  localparam logic signed [XY_W-1:0] WIN_MIN_RST = 16'sh7FFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_MEASURE = 3'd0,
    KIND_CAL_RESTART = 3'd1,
    KIND_CAL_SAMPLE = 3'd2,
    KIND_CAL_FINISH = 3'd3,
    KIND_LOAD = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ITER,
    ST_ROUND,
    ST_EMIT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic decode;
    logic step;
    logic round;
    logic emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_cordic;
  } sts_t;

  // atan(2^-i) in degrees scaled by 2^ANGLE_FRAC
  function automatic logic [ATAN_W-1:0] atan_deg(input logic [4:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:  v = 29'd377487360;
      5'd1:  v = 29'd222843801;
      5'd2:  v = 29'd117744544;
      5'd3:  v = 29'd59768969;
      5'd4:  v = 29'd30000467;
      5'd5:  v = 29'd15014858;
      5'd6:  v = 29'd7509261;
      5'd7:  v = 29'd3754860;
      5'd8:  v = 29'd1877459;
      5'd9:  v = 29'd938733;
      5'd10: v = 29'd469367;
      5'd11: v = 29'd234683;
      5'd12: v = 29'd117342;
      5'd13: v = 29'd58671;
      5'd14: v = 29'd29335;
      5'd15: v = 29'd14668;
      5'd16: v = 29'd7334;
      5'd17: v = 29'd3667;
      5'd18: v = 29'd1833;
      5'd19: v = 29'd917;
      5'd20: v = 29'd458;
      5'd21: v = 29'd229;
      5'd22: v = 29'd115;
      5'd23: v = 29'd57;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/chh_in_if.sv */
interface chh_in_if;
  logic valid;
  logic ready;
  logic [chh_pkg::KIND_W-1:0] kind;
  logic signed [chh_pkg::XY_W-1:0] x_in;
  logic signed [chh_pkg::XY_W-1:0] y_in;
  logic signed [chh_pkg::XY_W-1:0] z_in;
  logic data_ready;
  logic overflow;

  modport source (
    output valid, kind, x_in, y_in, z_in, data_ready, overflow,
    input ready
  );

  modport sink (
    input valid, kind, x_in, y_in, z_in, data_ready, overflow,
    output ready
  );
endinterface

/* rtl/chh_out_if.sv */
interface chh_out_if;
  logic valid;
  logic ready;
  logic [chh_pkg::XY_W-1:0] heading;
  logic signed [chh_pkg::XY_W-1:0] x_corrected;
  logic signed [chh_pkg::XY_W-1:0] y_corrected;
  logic signed [chh_pkg::XY_W-1:0] z_value;
  logic updated;
  logic signed [chh_pkg::XY_W-1:0] x_offset_now;
  logic signed [chh_pkg::XY_W-1:0] y_offset_now;

  modport source (
    output valid, heading, x_corrected, y_corrected, z_value, updated,
    x_offset_now, y_offset_now,
    input ready
  );

  modport sink (
    input valid, heading, x_corrected, y_corrected, z_value, updated,
    x_offset_now, y_offset_now,
    output ready
  );
endinterface

/* rtl/chh_ctrl.sv */
module chh_ctrl #(
  parameter int CORDIC_STEPS = chh_pkg::CORDIC_STEPS_DEF,
  parameter int IW = $clog2(CORDIC_STEPS)
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  chh_pkg::sts_t sts,
  output chh_pkg::cmd_t cmd,
  output logic [IW-1:0] step_idx
);

  localparam logic [IW-1:0] LAST_STEP = IW'(CORDIC_STEPS - 1);

  chh_pkg::state_t state_r, state_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;

  // State, step counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= chh_pkg::ST_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Sequence one transaction: capture, decode, CORDIC steps and round when needed, emit
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      chh_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = chh_pkg::ST_DECODE;
        end
      end
      chh_pkg::ST_DECODE: begin
        cmd.decode = 1'b1;
        cnt_nxt = '0;
        state_nxt = sts.need_cordic ? chh_pkg::ST_ITER : chh_pkg::ST_EMIT;
      end
      chh_pkg::ST_ITER: begin
        cmd.step = 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = chh_pkg::ST_ROUND;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      chh_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = chh_pkg::ST_EMIT;
      end
      chh_pkg::ST_EMIT: begin
        // Load the output register once it is free
        if (!out_valid_r || out_ready) begin
          cmd.emit = 1'b1;
          state_nxt = chh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = chh_pkg::ST_IDLE;
      end
    endcase
  end

  // Hold the result until taken
  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign step_idx = cnt_r;

endmodule

/* rtl/chh_dpath.sv */
module chh_dpath #(
  parameter int HEADING_FRACTION_BITS = chh_pkg::HEADING_FRAC_DEF,
  parameter int IW = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  chh_pkg::cmd_t cmd,
  output chh_pkg::sts_t sts,
  input  logic [IW-1:0] step_idx,
  input  logic [chh_pkg::KIND_W-1:0] in_kind,
  input  logic signed [chh_pkg::XY_W-1:0] in_x,
  input  logic signed [chh_pkg::XY_W-1:0] in_y,
  input  logic signed [chh_pkg::XY_W-1:0] in_z,
  input  logic in_data_ready,
  input  logic in_overflow,
  output logic [chh_pkg::XY_W-1:0] out_heading,
  output logic signed [chh_pkg::XY_W-1:0] out_x_corrected,
  output logic signed [chh_pkg::XY_W-1:0] out_y_corrected,
  output logic signed [chh_pkg::XY_W-1:0] out_z_value,
  output logic out_updated,
  output logic signed [chh_pkg::XY_W-1:0] out_x_offset_now,
  output logic signed [chh_pkg::XY_W-1:0] out_y_offset_now
);

  localparam int AW = chh_pkg::ANGLE_W;
  localparam int XW = chh_pkg::XY_W;
  localparam int SHIFT = chh_pkg::ANGLE_FRAC - HEADING_FRACTION_BITS;
  localparam int HW = XW + 1;
  localparam logic signed [AW-1:0] FULL_TURN = AW'(64'd360 << chh_pkg::ANGLE_FRAC);
  localparam logic signed [AW-1:0] HALF_TURN = AW'(64'd180 << chh_pkg::ANGLE_FRAC);
  localparam logic signed [AW-1:0] RND_HALF = AW'(64'd1 << (SHIFT - 1));
  localparam logic [HW-1:0] CIRCLE = HW'(64'd360 << HEADING_FRACTION_BITS);

  // Captured item
  chh_pkg::kind_t kind_r;
  logic signed [XW-1:0] xi_r, yi_r, zi_r;
  logic rdy_r, ovf_r;

  // Architectural state
  logic signed [XW-1:0] x_off_r, y_off_r;
  logic signed [XW-1:0] x_max_r, x_min_r, y_max_r, y_min_r;
  logic signed [XW-1:0] x_last_r, y_last_r, z_last_r;
  logic [XW-1:0] head_r;
  logic upd_r;

  // CORDIC working registers
  logic signed [AW-1:0] cx_r, cy_r, cz_r;

  // Output register
  logic [XW-1:0] o_head_r;
  logic signed [XW-1:0] o_x_r, o_y_r, o_z_r, o_xoff_r, o_yoff_r;
  logic o_upd_r;

  logic signed [XW-1:0] xc, yc;
  logic meas_ok, corr_zero, load_ok;
  logic signed [AW-1:0] x0, y0;
  logic signed [XW:0] x_sum, y_sum;
  logic signed [XW:0] x_mid, y_mid;
  logic signed [AW-1:0] dx, dy, ang;
  logic signed [AW-1:0] z_pos, z_rnd;
  logic [HW-1:0] h_val;

  // Correct by offsets with 16-bit wrap
  assign xc = xi_r - x_off_r;
  assign yc = yi_r - y_off_r;
  assign meas_ok = rdy_r && !ovf_r && !(xi_r == '0 && yi_r == '0);
  assign corr_zero = (xc == '0) && (yc == '0);
  assign load_ok = (xi_r > -chh_pkg::LOAD_LIMIT) && (xi_r < chh_pkg::LOAD_LIMIT) &&
                   (yi_r > -chh_pkg::LOAD_LIMIT) && (yi_r < chh_pkg::LOAD_LIMIT);
  assign sts.need_cordic = (kind_r == chh_pkg::KIND_MEASURE) && meas_ok && !corr_zero;

  // Prescaled start vector
  assign x0 = AW'(xc) <<< chh_pkg::PRESCALE_SHIFT;
  assign y0 = AW'(yc) <<< chh_pkg::PRESCALE_SHIFT;

  // Window midpoint, truncated toward zero
  assign x_sum = (XW+1)'(x_max_r) + (XW+1)'(x_min_r);
  assign y_sum = (XW+1)'(y_max_r) + (XW+1)'(y_min_r);
  assign x_mid = (x_sum + (XW+1)'(x_sum[XW])) >>> 1;
  assign y_mid = (y_sum + (XW+1)'(y_sum[XW])) >>> 1;

  // One vectoring step
  assign dx = cy_r >>> step_idx;
  assign dy = cx_r >>> step_idx;
  assign ang = AW'($signed({1'b0, chh_pkg::atan_deg(5'(step_idx))}));

  // Fold into one turn and round to heading units
  assign z_pos = cz_r[AW-1] ? cz_r + FULL_TURN : cz_r;
  assign z_rnd = z_pos + RND_HALF;
  assign h_val = HW'($unsigned(z_rnd) >> SHIFT);

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= chh_pkg::kind_t'(in_kind);
      xi_r <= in_x;
      yi_r <= in_y;
      zi_r <= in_z;
      rdy_r <= in_data_ready;
      ovf_r <= in_overflow;
    end
  end

  // Apply the item to the state, then write the rounded heading
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_off_r <= '0;
      y_off_r <= '0;
      x_max_r <= chh_pkg::WIN_MAX_RST;
      x_min_r <= chh_pkg::WIN_MIN_RST;
      y_max_r <= chh_pkg::WIN_MAX_RST;
      y_min_r <= chh_pkg::WIN_MIN_RST;
      x_last_r <= '0;
      y_last_r <= '0;
      z_last_r <= '0;
      head_r <= '0;
      upd_r <= 1'b0;
    end else if (cmd.decode) begin
      upd_r <= 1'b0;
      case (kind_r)
        chh_pkg::KIND_MEASURE: begin
          if (meas_ok) begin
            x_last_r <= xc;
            y_last_r <= yc;
            z_last_r <= zi_r;
            upd_r <= 1'b1;
            if (corr_zero) begin
              head_r <= '0;
            end
          end
        end
        chh_pkg::KIND_CAL_RESTART: begin
          x_max_r <= chh_pkg::WIN_MAX_RST;
          x_min_r <= chh_pkg::WIN_MIN_RST;
          y_max_r <= chh_pkg::WIN_MAX_RST;
          y_min_r <= chh_pkg::WIN_MIN_RST;
        end
        chh_pkg::KIND_CAL_SAMPLE: begin
          if (xi_r > x_max_r) x_max_r <= xi_r;
          if (xi_r < x_min_r) x_min_r <= xi_r;
          if (yi_r > y_max_r) y_max_r <= yi_r;
          if (yi_r < y_min_r) y_min_r <= yi_r;
        end
        chh_pkg::KIND_CAL_FINISH: begin
          x_off_r <= x_mid[XW-1:0];
          y_off_r <= y_mid[XW-1:0];
          upd_r <= 1'b1;
        end
        chh_pkg::KIND_LOAD: begin
          if (load_ok) begin
            x_off_r <= xi_r;
            y_off_r <= yi_r;
            upd_r <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.round) begin
      head_r <= (h_val >= CIRCLE) ? '0 : h_val[XW-1:0];
    end
  end

  // CORDIC vector and angle: pre-rotate to the right half plane, then step
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      if (xc[XW-1]) begin
        cx_r <= -x0;
        cy_r <= -y0;
        cz_r <= HALF_TURN;
      end else begin
        cx_r <= x0;
        cy_r <= y0;
        cz_r <= '0;
      end
    end else if (cmd.step) begin
      if (cy_r > 0) begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        cz_r <= cz_r + ang;
      end else begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        cz_r <= cz_r - ang;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_head_r <= head_r;
      o_x_r <= x_last_r;
      o_y_r <= y_last_r;
      o_z_r <= z_last_r;
      o_upd_r <= upd_r;
      o_xoff_r <= x_off_r;
      o_yoff_r <= y_off_r;
    end
  end

  assign out_heading = o_head_r;
  assign out_x_corrected = o_x_r;
  assign out_y_corrected = o_y_r;
  assign out_z_value = o_z_r;
  assign out_updated = o_upd_r;
  assign out_x_offset_now = o_xoff_r;
  assign out_y_offset_now = o_yoff_r;

endmodule

/* rtl/compass_heading_hard_iron_core.sv */
// Compass heading with hard-iron calibration. One result transaction is
// produced for every input transaction. A measure item that yields a new
// heading passes from acceptance to result through capture, decode,
// CORDIC_STEPS vectoring steps (16 by default) on a single shared shift-add
// unit, round and output load; all other items pass through capture, decode
// and output load only. Items are worked one at a time; the next item is
// accepted as soon as the previous result sits in the output register, and
// a result waits in the emit state only if that register is still
// full. Heading is in units of 1/2^HEADING_FRACTION_BITS degree, 0 up to
// just below 360 degrees, counterclockwise from +x.
module compass_heading_hard_iron_core #(
  parameter int CORDIC_STEPS = chh_pkg::CORDIC_STEPS_DEF,
  parameter int HEADING_FRACTION_BITS = chh_pkg::HEADING_FRAC_DEF
) (
  input logic clk,
  input logic rst_n,
  chh_in_if.sink in_chan,
  chh_out_if.source out_chan
);

  localparam int IW = $clog2(CORDIC_STEPS);

  chh_pkg::cmd_t cmd;
  chh_pkg::sts_t sts;
  logic [IW-1:0] step_idx;

  chh_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .IW(IW)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_chan.valid),
    .in_ready(in_chan.ready),
    .out_valid(out_chan.valid),
    .out_ready(out_chan.ready),
    .sts(sts),
    .cmd(cmd),
    .step_idx(step_idx)
  );

  chh_dpath #(
    .HEADING_FRACTION_BITS(HEADING_FRACTION_BITS),
    .IW(IW)
  ) u_dpath (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .sts(sts),
    .step_idx(step_idx),
    .in_kind(in_chan.kind),
    .in_x(in_chan.x_in),
    .in_y(in_chan.y_in),
    .in_z(in_chan.z_in),
    .in_data_ready(in_chan.data_ready),
    .in_overflow(in_chan.overflow),
    .out_heading(out_chan.heading),
    .out_x_corrected(out_chan.x_corrected),
    .out_y_corrected(out_chan.y_corrected),
    .out_z_value(out_chan.z_value),
    .out_updated(out_chan.updated),
    .out_x_offset_now(out_chan.x_offset_now),
    .out_y_offset_now(out_chan.y_offset_now)
  );

endmodule

/* rtl/chh_checker.sv */
module chh_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [chh_pkg::XY_W-1:0] out_heading
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_heading))
    else $error("result changed while stalled");

  // One transaction in flight: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // A new result frees the input side
  a_ready_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("input not ready when a result appears");

  // Heading stays below a full turn
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_heading < 16'd46080)
    else $error("heading out of range");

  // No result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind compass_heading_hard_iron_core chh_checker u_chh_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_chan.valid),
  .in_ready(in_chan.ready),
  .out_valid(out_chan.valid),
  .out_ready(out_chan.ready),
  .out_heading(out_chan.heading)
);
